/* rtl/mvt_pkg.sv */
package mvt_pkg;

    localparam int FP_W       = 32;
    localparam int CFG_W      = 64;
    localparam int NUM_REGS   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_LANES  = 4;
    localparam int MUL_STAGES = 3;
    localparam int ADD_STAGES = 4;
    localparam int LATENCY    = MUL_STAGES + 2 * ADD_STAGES;

    localparam logic [FP_W-1:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [7:0]      EXP_MAX   = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COL0_XY,
        REG_COL0_ZW,
        REG_COL1_XY,
        REG_COL1_ZW,
        REG_COL2_XY,
        REG_COL2_ZW,
        REG_COL3_XY,
        REG_COL3_ZW
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_3F80_0000,
        64'h0000_0000_0000_0000,
        64'h3F80_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_3F80_0000,
        64'h0000_0000_0000_0000,
        64'h3F80_0000_0000_0000
    };

    typedef struct packed {
        logic [FP_W-1:0] vec_x;
        logic [FP_W-1:0] vec_y;
        logic [FP_W-1:0] vec_z;
        logic [FP_W-1:0] vec_w;
    } vec_in_t;

    typedef struct packed {
        logic [FP_W-1:0] res_x;
        logic [FP_W-1:0] res_y;
        logic [FP_W-1:0] res_z;
        logic [FP_W-1:0] res_w;
    } vec_out_t;

    typedef struct packed {
        logic nan;
        logic inf;
        logic inf_sign;
    } fp_special_t;

    function automatic logic fp_is_nan(input logic [FP_W-1:0] v);
        return (v[30:23] == EXP_MAX) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic fp_is_inf(input logic [FP_W-1:0] v);
        return (v[30:23] == EXP_MAX) && (v[22:0] == 23'd0);
    endfunction

endpackage

/* rtl/mvt_fmul.sv */
module mvt_fmul (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [mvt_pkg::FP_W-1:0] a,
    input  logic [mvt_pkg::FP_W-1:0] b,
    output logic [mvt_pkg::FP_W-1:0] y
);
    import mvt_pkg::*;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++) begin
            if (v[i]) begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    logic [7:0]  ea_eff, eb_eff;
    logic [23:0] ma, mb;
    logic        s1_nan, s1_inf, s1_zero;

    logic [47:0] prod_reg;
    logic [8:0]  esum_reg;
    logic        sign1_reg, nan1_reg, inf1_reg, zero1_reg;

    always_comb begin
        ea_eff  = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb_eff  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma      = {a[30:23] != 8'd0, a[22:0]};
        mb      = {b[30:23] != 8'd0, b[22:0]};
        s1_zero = (a[30:0] == 31'd0) || (b[30:0] == 31'd0);
        s1_nan  = fp_is_nan(a) || fp_is_nan(b)
                || (fp_is_inf(a) && (b[30:0] == 31'd0))
                || (fp_is_inf(b) && (a[30:0] == 31'd0));
        s1_inf  = fp_is_inf(a) || fp_is_inf(b);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg  <= ma * mb;
            esum_reg  <= {1'b0, ea_eff} + {1'b0, eb_eff};
            sign1_reg <= a[31] ^ b[31];
            nan1_reg  <= s1_nan;
            inf1_reg  <= s1_inf;
            zero1_reg <= s1_zero;
        end
    end

    logic [5:0]         lz;
    logic [47:0]        norm;
    logic signed [10:0] er;

    logic [47:0]        norm2_reg;
    logic signed [10:0] er2_reg;
    logic               sign2_reg, nan2_reg, inf2_reg, zero2_reg;

    always_comb begin
        lz   = lzc48(prod_reg);
        norm = prod_reg << lz;
        er   = $signed({2'b00, esum_reg}) - 11'sd126 - $signed({5'd0, lz});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            norm2_reg <= norm;
            er2_reg   <= er;
            sign2_reg <= sign1_reg;
            nan2_reg  <= nan1_reg;
            inf2_reg  <= inf1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    logic [10:0] sh_full;
    logic [5:0]  sh;
    logic [47:0] shifted;
    logic [48:0] mask;
    logic        lost, g, st, ru;
    logic [23:0] m;
    logic [7:0]  field;
    logic [30:0] mag;
    logic [FP_W-1:0] y_next;
    logic [FP_W-1:0] y_reg;

    always_comb begin
        sh_full = 11'(11'sd1 - er2_reg);
        sh      = (er2_reg >= 11'sd1) ? 6'd0
                : ((sh_full > 11'd48) ? 6'd48 : sh_full[5:0]);
        mask    = (49'd1 << sh) - 49'd1;
        lost    = |(norm2_reg & mask[47:0]);
        shifted = norm2_reg >> sh;
        m       = shifted[47:24];
        g       = shifted[23];
        st      = (|shifted[22:0]) || lost;
        ru      = g && (st || m[0]);
        field   = (er2_reg >= 11'sd1) ? er2_reg[7:0] : 8'd0;
        mag     = {field, m[22:0]} + {30'd0, ru};
        if (nan2_reg) begin
            y_next = CANON_NAN;
        end else if (inf2_reg || (!zero2_reg && (er2_reg >= 11'sd255))) begin
            y_next = {sign2_reg, EXP_MAX, 23'd0};
        end else if (zero2_reg) begin
            y_next = {sign2_reg, 31'd0};
        end else begin
            y_next = {sign2_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

/* rtl/mvt_fadd.sv */
module mvt_fadd (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [mvt_pkg::FP_W-1:0] a,
    input  logic [mvt_pkg::FP_W-1:0] b,
    output logic [mvt_pkg::FP_W-1:0] y
);
    import mvt_pkg::*;

    function automatic logic [4:0] lzc27(input logic [26:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 27; i++) begin
            if (v[i]) begin
                n = 5'(26 - i);
            end
        end
        return n;
    endfunction

    logic [FP_W-1:0] big, little;
    fp_special_t     sp1;

    logic [23:0] bigm1_reg, smallm1_reg;
    logic [7:0]  ebig1_reg, d1_reg;
    logic        sub1_reg, sign1_reg;
    fp_special_t sp1_reg;

    always_comb begin
        if (a[30:0] >= b[30:0]) begin
            big    = a;
            little = b;
        end else begin
            big    = b;
            little = a;
        end
        sp1.nan      = fp_is_nan(a) || fp_is_nan(b)
                     || (fp_is_inf(a) && fp_is_inf(b) && (a[31] != b[31]));
        sp1.inf      = fp_is_inf(a) || fp_is_inf(b);
        sp1.inf_sign = fp_is_inf(a) ? a[31] : b[31];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bigm1_reg   <= {big[30:23] != 8'd0, big[22:0]};
            smallm1_reg <= {little[30:23] != 8'd0, little[22:0]};
            ebig1_reg   <= (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
            d1_reg      <= ((big[30:23] == 8'd0) ? 8'd1 : big[30:23])
                         - ((little[30:23] == 8'd0) ? 8'd1 : little[30:23]);
            sub1_reg    <= a[31] ^ b[31];
            sign1_reg   <= big[31];
            sp1_reg     <= sp1;
        end
    end

    logic [4:0]  dc;
    logic [26:0] ext, al;
    logic [27:0] amask;
    logic [27:0] sum;

    logic [27:0] sum2_reg;
    logic [7:0]  ebig2_reg;
    logic        sub2_reg, sign2_reg;
    fp_special_t sp2_reg;

    always_comb begin
        dc    = (d1_reg > 8'd27) ? 5'd27 : d1_reg[4:0];
        ext   = {smallm1_reg, 3'b000};
        amask = (28'd1 << dc) - 28'd1;
        al    = ext >> dc;
        al[0] = al[0] | (|(ext & amask[26:0]));
        if (sub1_reg) begin
            sum = {1'b0, bigm1_reg, 3'b000} - {1'b0, al};
        end else begin
            sum = {1'b0, bigm1_reg, 3'b000} + {1'b0, al};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum2_reg  <= sum;
            ebig2_reg <= ebig1_reg;
            sub2_reg  <= sub1_reg;
            sign2_reg <= sign1_reg;
            sp2_reg   <= sp1_reg;
        end
    end

    logic [4:0]  lz;
    logic [7:0]  lim, sh;
    logic [26:0] n;
    logic [8:0]  e;

    logic [26:0] n3_reg;
    logic [8:0]  e3_reg;
    logic        sign3_reg;
    fp_special_t sp3_reg;

    always_comb begin
        lz  = lzc27(sum2_reg[26:0]);
        lim = ebig2_reg - 8'd1;
        sh  = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
        if (sum2_reg[27]) begin
            n = {sum2_reg[27:2], sum2_reg[1] | sum2_reg[0]};
            e = {1'b0, ebig2_reg} + 9'd1;
        end else begin
            n = sum2_reg[26:0] << sh;
            e = {1'b0, ebig2_reg} - {1'b0, sh};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n3_reg    <= n;
            e3_reg    <= e;
            sign3_reg <= (sub2_reg && (sum2_reg == 28'd0)) ? 1'b0 : sign2_reg;
            sp3_reg   <= sp2_reg;
        end
    end

    logic            ru;
    logic [7:0]      field;
    logic [30:0]     mag;
    logic [FP_W-1:0] y_next;
    logic [FP_W-1:0] y_reg;

    always_comb begin
        ru    = n3_reg[2] && (n3_reg[1] || n3_reg[0] || n3_reg[3]);
        field = n3_reg[26] ? e3_reg[7:0] : 8'd0;
        mag   = {field, n3_reg[25:3]} + {30'd0, ru};
        if (sp3_reg.nan) begin
            y_next = CANON_NAN;
        end else if (sp3_reg.inf) begin
            y_next = {sp3_reg.inf_sign, EXP_MAX, 23'd0};
        end else if (e3_reg >= 9'd255) begin
            y_next = {sign3_reg, EXP_MAX, 23'd0};
        end else begin
            y_next = {sign3_reg, mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

/* rtl/mat4_vec4_transform_core.sv */
// Channel   Direction  Word                           Handshake
// s_        in         vec_x, vec_y, vec_z, vec_w     s_valid / s_ready
// m_        out        res_x, res_y, res_z, res_w     m_valid / m_ready
// cfg_      in         eight 64-bit matrix registers  cfg_we, no wait
//
// One word enters per cycle while the output does not stall and passes eleven
// register stages: three multiplier stages followed by two four-stage adder
// levels in each lane.
// Reset clears the valid bits and loads the identity matrix.
// A stall at the output freezes the whole pipeline, so no word is lost or repeated.
module mat4_vec4_transform_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mvt_pkg::vec_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mvt_pkg::vec_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [mvt_pkg::CFG_W-1:0]     cfg_wdata
);
    import mvt_pkg::*;

    logic [CFG_W-1:0]   cfg_reg [NUM_REGS];
    logic [LATENCY-1:0] vld_reg;
    logic               en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else if (cfg_we) begin
            cfg_reg[cfg_idx] <= cfg_wdata;
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[LATENCY-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LATENCY-2:0], s_valid};
        end
    end

    logic [FP_W-1:0] vin [NUM_LANES];
    logic [FP_W-1:0] res [NUM_LANES];

    assign vin[0] = s_data.vec_x;
    assign vin[1] = s_data.vec_y;
    assign vin[2] = s_data.vec_z;
    assign vin[3] = s_data.vec_w;

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        logic [FP_W-1:0] prod [NUM_LANES];
        logic [FP_W-1:0] s01, s23;

        for (genvar c = 0; c < NUM_LANES; c++) begin : g_col
            localparam logic [CFG_IDX_W-1:0] RIDX = CFG_IDX_W'(c * 2 + l / 2);
            logic [FP_W-1:0] elem;

            assign elem = (l % 2 == 1) ? cfg_reg[RIDX][CFG_W-1:FP_W]
                                       : cfg_reg[RIDX][FP_W-1:0];

            mvt_fmul u_mul (
                .aclk (aclk),
                .en   (en),
                .a    (elem),
                .b    (vin[c]),
                .y    (prod[c])
            );
        end

        mvt_fadd u_add01 (
            .aclk (aclk),
            .en   (en),
            .a    (prod[0]),
            .b    (prod[1]),
            .y    (s01)
        );

        mvt_fadd u_add23 (
            .aclk (aclk),
            .en   (en),
            .a    (prod[2]),
            .b    (prod[3]),
            .y    (s23)
        );

        mvt_fadd u_add_out (
            .aclk (aclk),
            .en   (en),
            .a    (s01),
            .b    (s23),
            .y    (res[l])
        );
    end

    assign m_data.res_x = res[0];
    assign m_data.res_y = res[1];
    assign m_data.res_z = res[2];
    assign m_data.res_w = res[3];

`ifndef SYNTHESIS
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("pipeline not empty after reset");

    a_stall_freeze : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    a_nan_x : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && fp_is_nan(m_data.res_x) |-> m_data.res_x == CANON_NAN)
        else $error("non-canonical NaN on res_x");

    a_nan_w : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && fp_is_nan(m_data.res_w) |-> m_data.res_w == CANON_NAN)
        else $error("non-canonical NaN on res_w");
`endif

endmodule

/* test/mvt_result_checker.sv */
module mvt_result_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  mvt_pkg::vec_in_t              s_data,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  mvt_pkg::vec_out_t             m_data,
    input  logic                          cfg_we,
    input  logic [mvt_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [mvt_pkg::CFG_W-1:0]     cfg_wdata,
    output int                            errors,
    output int                            pending,
    output int                            received
);
    import mvt_pkg::*;

    logic [CFG_W-1:0] matrix_regs [NUM_REGS];
    vec_out_t         transformed_q [$];

    function automatic logic is_nan32(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
    endfunction

    function automatic logic is_inf32(input logic [31:0] v);
        return (v[30:23] == 8'hFF) && (v[22:0] == 23'd0);
    endfunction

    function automatic void split32(input logic [31:0] v, output logic s,
                                    output logic [23:0] m, output int q);
        s = v[31];
        if (v[30:23] == 8'd0) begin
            m = {1'b0, v[22:0]};
            q = -149;
        end else begin
            m = {1'b1, v[22:0]};
            q = int'(v[30:23]) - 150;
        end
    endfunction

    // The value is (-1)^s * m * 2^q, rounded once to binary32, nearest even.
    function automatic logic [31:0] round32(input logic s, input logic [127:0] m, input int q);
        int p;
        int e;
        int sh;
        logic [127:0] mant;
        logic [127:0] rem;
        logic [127:0] half;
        if (m == 128'd0) return {s, 31'd0};
        p = 127;
        while (!m[p]) p--;
        e = p + q;
        sh = (e >= -126) ? p - 23 : -149 - q;
        if (sh > 120) return {s, 31'd0};
        if (sh <= 0) begin
            mant = m << (-sh);
        end else begin
            mant = m >> sh;
            rem  = m & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && mant[0])) mant = mant + 128'd1;
        end
        if (e < -126) return {s, mant[30:0]};
        if (mant[24]) e++;
        if (e > 127) return {s, 8'hFF, 23'd0};
        return {s, 8'(e + 127), mant[22:0]};
    endfunction

    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic sa;
        logic sb;
        logic [23:0] ma;
        logic [23:0] mb;
        int qa;
        int qb;
        logic [127:0] prod;
        if (is_nan32(a) || is_nan32(b)) return CANON_NAN;
        if ((is_inf32(a) && b[30:0] == 31'd0) || (is_inf32(b) && a[30:0] == 31'd0))
            return CANON_NAN;
        if (is_inf32(a) || is_inf32(b)) return {a[31] ^ b[31], 8'hFF, 23'd0};
        split32(a, sa, ma, qa);
        split32(b, sb, mb, qb);
        prod = 128'(ma) * 128'(mb);
        return round32(sa ^ sb, prod, qa + qb);
    endfunction

    function automatic logic [31:0] add32(input logic [31:0] a, input logic [31:0] b);
        logic sa;
        logic sb;
        logic st;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [23:0] mt;
        int qa;
        int qb;
        int qt;
        int d;
        int q;
        logic [127:0] big;
        logic [127:0] lesser;
        if (is_nan32(a) || is_nan32(b)) return CANON_NAN;
        if (is_inf32(a) && is_inf32(b)) return (a[31] != b[31]) ? CANON_NAN : a;
        if (is_inf32(a)) return a;
        if (is_inf32(b)) return b;
        split32(a, sa, ma, qa);
        split32(b, sb, mb, qb);
        if (ma == 24'd0 && mb == 24'd0) return {sa & sb, 31'd0};
        if (qa < qb) begin
            st = sa; mt = ma; qt = qa;
            sa = sb; ma = mb; qa = qb;
            sb = st; mb = mt; qb = qt;
        end
        d = qa - qb;
        // Beyond fifty bits of separation the smaller operand only acts as a sticky bit.
        if (d > 50) begin
            big    = 128'(ma) << 50;
            lesser = (mb != 24'd0) ? 128'd1 : 128'd0;
            q      = qa - 50;
        end else begin
            big    = 128'(ma) << d;
            lesser = 128'(mb);
            q      = qb;
        end
        if (sa == sb) return round32(sa, big + lesser, q);
        if (big == lesser) return 32'd0;
        if (big > lesser) return round32(sa, big - lesser, q);
        return round32(sb, lesser - big, q);
    endfunction

    function automatic logic [31:0] matrix_elem(input int col, input int lane);
        logic [CFG_W-1:0] r;
        r = matrix_regs[col * 2 + lane / 2];
        return (lane % 2) ? r[63:32] : r[31:0];
    endfunction

    function automatic vec_out_t transform(input vec_in_t v);
        logic [127:0] res;
        logic [31:0] lo;
        logic [31:0] hi;
        for (int lane = 0; lane < NUM_LANES; lane++) begin
            lo = add32(mul32(matrix_elem(0, lane), v.vec_x), mul32(matrix_elem(1, lane), v.vec_y));
            hi = add32(mul32(matrix_elem(2, lane), v.vec_z), mul32(matrix_elem(3, lane), v.vec_w));
            res[127 - 32 * lane -: 32] = add32(lo, hi);
        end
        return vec_out_t'(res);
    endfunction

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch %s: expected %08h, got %08h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    always @(posedge aclk) begin
        vec_out_t want;
        if (!aresetn) begin
            foreach (matrix_regs[i]) matrix_regs[i] = CFG_RESET[i];
            transformed_q.delete();
            errors   = 0;
            received = 0;
        end else begin
            if (s_valid && s_ready) transformed_q.push_back(transform(s_data));
            if (cfg_we) matrix_regs[cfg_idx] = cfg_wdata;
            if (m_valid && m_ready) begin
                received++;
                if (transformed_q.size() == 0) begin
                    report("unexpected word", 32'd0, m_data.res_x);
                end else begin
                    want = transformed_q.pop_front();
                    for (int lane = 0; lane < NUM_LANES; lane++) begin
                        if (want[127 - 32 * lane -: 32] !== m_data[127 - 32 * lane -: 32])
                            report($sformatf("lane %0d", lane), want[127 - 32 * lane -: 32],
                                   m_data[127 - 32 * lane -: 32]);
                    end
                end
            end
        end
        pending = transformed_q.size();
    end

endmodule

/* test/mat4_vec4_transform_core_tb.sv */
module mat4_vec4_transform_core_tb;
    import mvt_pkg::*;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    vec_in_t              s_data    = '0;
    logic                 m_ready   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_ready;
    logic                 m_valid;
    vec_out_t             m_data;

    int errors;
    int pending;
    int received;
    int sent = 0;
    bit idling = 1'b1;
    bit hold_req = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    mat4_vec4_transform_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
    );

    mvt_result_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
        .errors(errors), .pending(pending), .received(received)
    );

    always begin
        @(posedge aclk);
        if (hold_req) begin
            m_ready <= 1'b0;
            repeat (300) @(posedge aclk);
            hold_req = 1'b0;
        end else if (idling && $urandom_range(0, 7) == 0) begin
            m_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        m_ready <= 1'b1;
    end

    function automatic logic [31:0] pick_float();
        logic sgn;
        sgn = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 15))
            0:       return {sgn, 31'd0};
            1:       return {sgn, 8'hFF, 23'd0};
            2:       return {sgn, 8'hFF, 23'($urandom_range(1, 32'h7FFFFF))};
            3:       return {sgn, 31'h7F7FFFFF};
            4:       return {sgn, 8'd0, 23'($urandom)};
            5:       return {sgn, 8'd1, 23'($urandom_range(0, 3))};
            6, 7, 8, 9, 10, 11:
                     return {sgn, 8'($urandom_range(110, 144)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input vec_in_t v);
        bit rdy;
        if (idling && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= v;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
        sent++;
    endtask

    task automatic load_matrix(input logic [CFG_W-1:0] m [NUM_REGS]);
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_we    <= 1'b1;
            cfg_idx   <= cfg_reg_t'(i);
            cfg_wdata <= m[i];
            @(posedge aclk);
        end
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    vec_in_t          identity_words [12];
    vec_in_t          ones_words [9];
    logic [CFG_W-1:0] matrix [NUM_REGS];
    vec_in_t          v;

    initial begin
        identity_words = '{
            '{32'h3F800000, 32'h40000000, 32'hC0400000, 32'h3F000000},
            '{32'h00000000, 32'h80000000, 32'h00000000, 32'h80000000},
            '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
            '{32'h7F800000, 32'hFF800000, 32'h7FC00001, 32'hFFFFFFFF},
            '{32'h7F7FFFFF, 32'hFF7FFFFF, 32'h00800000, 32'h00000001},
            '{32'h007FFFFF, 32'h807FFFFF, 32'h3F800000, 32'hBF800000},
            '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
            '{32'h7FFFFFFF, 32'h00000001, 32'h80000001, 32'h7F800001},
            '{32'h12345678, 32'h9ABCDEF0, 32'h55555555, 32'hAAAAAAAA},
            '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000},
            '{32'h3F800000, 32'h3F800000, 32'h3F800000, 32'h3F800000},
            '{32'h4B000000, 32'hCB000000, 32'h00400000, 32'h7F000000}
        };
        ones_words = '{
            '{32'h7F800000, 32'hFF800000, 32'h00000000, 32'h00000000},
            '{32'h7F7FFFFF, 32'h7F7FFFFF, 32'h00000000, 32'h00000000},
            '{32'h00000001, 32'h80000001, 32'h00000000, 32'h00000000},
            '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
            '{32'h7F7FFFFF, 32'hFF7FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF},
            '{32'h3F800000, 32'h33800000, 32'h00000000, 32'h00000000},
            '{32'h3F800001, 32'h33800000, 32'h00000000, 32'h00000000},
            '{32'h00400000, 32'h00400000, 32'h00000000, 32'h00000000},
            '{32'h7F800000, 32'h7F800000, 32'hFF800000, 32'h3F800000}
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (identity_words[i]) send_word(identity_words[i]);
        drain();

        foreach (matrix[i]) matrix[i] = 64'h3F800000_3F800000;
        load_matrix(matrix);
        foreach (ones_words[i]) send_word(ones_words[i]);
        drain();

        for (int ph = 0; ph < 11; ph++) begin
            foreach (matrix[i]) begin
                case (ph)
                    0:       matrix[i] = '1;
                    1:       matrix[i] = '0;
                    2:       matrix[i] = 64'h7F7FFFFF_FF7FFFFF;
                    3:       matrix[i] = 64'h00000001_807FFFFF;
                    default: matrix[i] = {pick_float(), pick_float()};
                endcase
            end
            load_matrix(matrix);
            if (ph == 5) hold_req = 1'b1;
            if (ph == 10) idling = 1'b0;
            repeat (150) begin
                if ($urandom_range(0, 4) == 0)
                    v = {$urandom, $urandom, $urandom, $urandom};
                else
                    v = {pick_float(), pick_float(), pick_float(), pick_float()};
                send_word(v);
            end
            drain();
        end

        repeat (LATENCY + 5) @(posedge aclk);
        $display("Transformed %0d words and checked %0d results over 13 matrix settings,",
                 sent, received);
        $display("including special values, rounding ties and a long output stall.");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/mvt_pkg.sv
rtl/mvt_fmul.sv
rtl/mvt_fadd.sv
rtl/mat4_vec4_transform_core.sv
test/mvt_result_checker.sv
test/mat4_vec4_transform_core_tb.sv
